// ----- rtl/jrlp_pkg.sv -----
// Shared types and fixed constants of the joint rate low-pass filter.
package jrlp_pkg;

    localparam int TAPS     = 4;
    localparam int JOINT_W  = 3;
    localparam int SAMPLE_W = 32;
    localparam int HIST_W   = 56;
    localparam int COEF_W   = 34;
    localparam int GAIN_W   = 27;
    localparam int SUM_W    = 36;
    localparam int ACC_W    = 64;

    // 2^46 / GAIN, rounded
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 27'sd63225342;

    // Feedback taps in Q4.30, oldest output first
    localparam logic signed [COEF_W-1:0] FB_COEF [TAPS] = '{
        -34'sd911130066,
        34'sd3794104552,
        -34'sd5927934410,
        34'sd4118686313
    };

    localparam logic signed [HIST_W-1:0] Y_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] Y_MIN = {1'b1, {(HIST_W-1){1'b0}}};

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // One channel's delay lines, entry 0 oldest
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_W-1:0] x;
        logic [TAPS-1:0][HIST_W-1:0]   y;
    } jrlp_hist_t;

    // One joint's memory word
    typedef struct packed {
        jrlp_hist_t vel;
        jrlp_hist_t acc;
    } jrlp_entry_t;

    // Stage load strobes handed to each filter lane
    typedef struct packed {
        logic load_s2;
        logic load_s3;
        logic load_s4;
        logic load_s5;
    } jrlp_adv_t;

endpackage

// ----- rtl/jrlp_lane.sv -----
// One channel's filter datapath: binomial sum, products, accumulation, saturation.
module jrlp_lane (
    input  logic                                 clk,
    input  jrlp_pkg::jrlp_adv_t                  adv,
    input  jrlp_pkg::jrlp_hist_t                 hist_in,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] sample,
    output jrlp_pkg::jrlp_hist_t                 hist_wr,
    output logic signed [jrlp_pkg::SAMPLE_W-1:0] result
);
    import jrlp_pkg::*;

    localparam int HI_W  = HIST_W - 30;
    localparam int PFF_W = SUM_W + GAIN_W;
    localparam int PHI_W = COEF_W + HI_W;
    localparam int YR_W  = HIST_W + 1;

    localparam logic signed [PFF_W-1:0] FF_ROUND = PFF_W'(64'sd2097152);
    localparam logic signed [ACC_W-1:0] LO_ROUND = ACC_W'(64'sd536870912);
    localparam logic signed [YR_W-1:0]  Y_ROUND  = YR_W'(64'sd8388608);

    // stage 2
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [HI_W-1:0]  hi_reg [TAPS];
    logic signed [HI_W-1:0]  hi_next [TAPS];
    logic [29:0]             lo_reg [TAPS];
    logic [29:0]             lo_next [TAPS];
    jrlp_hist_t              hist2_reg, hist2_next;

    // stage 3
    logic signed [PFF_W-1:0] pff_reg, pff_next;
    logic signed [PHI_W-1:0] phi_reg [TAPS];
    logic signed [PHI_W-1:0] phi_next [TAPS];
    logic signed [ACC_W-1:0] plo_reg [TAPS];
    logic signed [ACC_W-1:0] plo_next [TAPS];
    jrlp_hist_t              hist3_reg;

    // stage 4
    logic signed [ACC_W-1:0] ff_reg, ff_next;
    logic signed [ACC_W-1:0] term_reg [TAPS];
    logic signed [ACC_W-1:0] term_next [TAPS];
    jrlp_hist_t              hist4_reg;

    // stage 5
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [HIST_W-1:0] y_sat;
    jrlp_hist_t              hist5_reg, hist5_next;

    logic signed [YR_W-1:0]     y_round;
    logic signed [SAMPLE_W:0]   y_q;

    always_comb
    begin
        logic signed [SAMPLE_W-1:0] x0, x1, x2, x3;
        logic signed [SUM_W-1:0]    mid;
        x0 = $signed(hist_in.x[0]);
        x1 = $signed(hist_in.x[1]);
        x2 = $signed(hist_in.x[2]);
        x3 = $signed(hist_in.x[3]);
        mid = SUM_W'(x1) + SUM_W'(x3);
        sum_next = SUM_W'(x0) + SUM_W'(sample) + (mid <<< 2)
                 + (SUM_W'(x2) <<< 2) + (SUM_W'(x2) <<< 1);
        for (int k = 0; k < TAPS; k++)
        begin
            hi_next[k] = $signed(hist_in.y[k][HIST_W-1:30]);
            lo_next[k] = hist_in.y[k][29:0];
        end
        // shift the delay lines; the newest output lands in stage 5
        hist2_next = '0;
        for (int k = 0; k < TAPS - 1; k++)
        begin
            hist2_next.x[k] = hist_in.x[k+1];
            hist2_next.y[k] = hist_in.y[k+1];
        end
        hist2_next.x[TAPS-1] = sample;
    end

    always_comb
    begin
        pff_next = sum_reg * INV_GAIN + FF_ROUND;
        for (int k = 0; k < TAPS; k++)
        begin
            phi_next[k] = FB_COEF[k] * hi_reg[k];
            plo_next[k] = FB_COEF[k] * $signed({1'b0, lo_reg[k]}) + LO_ROUND;
        end
    end

    always_comb
    begin
        ff_next = ACC_W'(pff_reg >>> 22);
        for (int k = 0; k < TAPS; k++)
        begin
            term_next[k] = ACC_W'(phi_reg[k]) + (plo_reg[k] >>> 30);
        end
    end

    always_comb
    begin
        acc_sum = ff_reg + term_reg[0] + term_reg[1] + term_reg[2] + term_reg[3];
        priority if (acc_sum > ACC_W'(Y_MAX))
            y_sat = Y_MAX;
        else if (acc_sum < ACC_W'(Y_MIN))
            y_sat = Y_MIN;
        else
            y_sat = acc_sum[HIST_W-1:0];
        hist5_next = hist4_reg;
        hist5_next.y[TAPS-1] = y_sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_s2)
        begin
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            hist2_reg <= hist2_next;
        end
        if (adv.load_s3)
        begin
            pff_reg   <= pff_next;
            phi_reg   <= phi_next;
            plo_reg   <= plo_next;
            hist3_reg <= hist2_reg;
        end
        if (adv.load_s4)
        begin
            ff_reg    <= ff_next;
            term_reg  <= term_next;
            hist4_reg <= hist3_reg;
        end
        if (adv.load_s5)
        begin
            hist5_reg <= hist5_next;
        end
    end

    // round to Q16.16; only the top can overflow
    always_comb
    begin
        y_round = YR_W'($signed(hist5_reg.y[TAPS-1])) + Y_ROUND;
        y_q     = y_round[YR_W-1:24];
        if (y_q > (SAMPLE_W+1)'(OUT_MAX))
            result = OUT_MAX;
        else
            result = y_q[SAMPLE_W-1:0];
    end

    assign hist_wr = hist5_reg;

endmodule

// ----- rtl/joint_rate_iir_lowpass_core.sv -----
// Top level: per-joint fourth-order low-pass on velocity and acceleration words.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | joint, velocity_sample, accel_sample
//  out     | out_valid/out_ready | joint_out, velocity_filtered, accel_filtered
//
// One word per cycle while no word for the same joint is in flight and the pipeline
// is not held up by a stalled output; each word passes stages 1 to 5, then the output register.
// The joint's history memory is read at acceptance and written back when the
// result leaves stage 5, so a word for a joint still in flight waits until that
// joint's result has left stage 5.
// Reset clears one valid flag per joint at once; an unflagged entry reads as zero.
// A stalled output holds its word; stages behind it keep filling until full.
module joint_rate_iir_lowpass_core #(
    parameter int JOINTS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [jrlp_pkg::JOINT_W-1:0]         joint,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_sample,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [jrlp_pkg::JOINT_W-1:0]         joint_out,
    output logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_filtered,
    output logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_filtered
);
    import jrlp_pkg::*;

    localparam int AW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int STAGES = 5;

    function automatic logic [AW-1:0] to_addr(input logic [JOINT_W-1:0] j);
        logic [AW+JOINT_W-1:0] ext;
        ext = {{AW{1'b0}}, j};
        return ext[AW-1:0];
    endfunction

    // history memory
    jrlp_entry_t hist_mem [JOINTS];
    jrlp_entry_t rdata_reg;
    jrlp_entry_t wdata;
    logic [JOINTS-1:0] entry_valid_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic wr_en;

    // stage control, index 0 is stage 1
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] inr_reg;
    logic [JOINT_W-1:0] joint_reg [STAGES];
    logic [STAGES-1:0] ld;
    logic hit_reg;
    logic signed [SAMPLE_W-1:0] vel1_reg, acc1_reg;

    logic ld_out;
    logic in_range;
    logic hazard;
    logic accept;

    jrlp_adv_t   adv;
    jrlp_entry_t hist1;
    logic signed [SAMPLE_W-1:0] vel_res, acc_res;

    logic out_valid_reg;
    logic [JOINT_W-1:0] joint_out_reg;
    logic signed [SAMPLE_W-1:0] vel_out_reg, acc_out_reg;

    assign ld_out   = !out_valid_reg || out_ready;
    assign in_range = int'(joint) < JOINTS;

    always_comb
    begin
        ld[STAGES-1] = !v_reg[STAGES-1] || ld_out;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    // interlock: hold a word whose joint is still in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (v_reg[i] && inr_reg[i] && joint_reg[i] == joint)
                hazard = 1'b1;
        end
        hazard = hazard && in_range;
    end

    assign in_ready = ld[0] && !hazard;
    assign accept   = in_valid && in_ready;

    assign rd_addr = to_addr(joint);
    assign wr_addr = to_addr(joint_reg[STAGES-1]);
    assign wr_en   = v_reg[STAGES-1] && inr_reg[STAGES-1] && ld_out;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wdata;
        if (accept)
            rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= '0;
        else if (wr_en)
            entry_valid_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (ld[0])
                v_reg[0] <= accept;
            for (int i = 1; i < STAGES; i++)
            begin
                if (ld[i])
                    v_reg[i] <= v_reg[i-1];
            end
            if (accept)
                hit_reg <= entry_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            joint_reg[0] <= joint;
            inr_reg[0]   <= in_range;
            vel1_reg     <= velocity_sample;
            acc1_reg     <= accel_sample;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (ld[i])
            begin
                joint_reg[i] <= joint_reg[i-1];
                inr_reg[i]   <= inr_reg[i-1];
            end
        end
    end

    assign hist1 = hit_reg ? rdata_reg : '0;

    assign adv.load_s2 = ld[1];
    assign adv.load_s3 = ld[2];
    assign adv.load_s4 = ld[3];
    assign adv.load_s5 = ld[4];

    jrlp_lane u_vel_lane (
        .clk     (clk),
        .adv     (adv),
        .hist_in (hist1.vel),
        .sample  (vel1_reg),
        .hist_wr (wdata.vel),
        .result  (vel_res)
    );

    jrlp_lane u_acc_lane (
        .clk     (clk),
        .adv     (adv),
        .hist_in (hist1.acc),
        .sample  (acc1_reg),
        .hist_wr (wdata.acc),
        .result  (acc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ld_out)
            out_valid_reg <= v_reg[STAGES-1];
    end

    // zero the filter results for a joint beyond the table
    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            joint_out_reg <= joint_reg[STAGES-1];
            vel_out_reg   <= inr_reg[STAGES-1] ? vel_res : '0;
            acc_out_reg   <= inr_reg[STAGES-1] ? acc_res : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign joint_out         = joint_out_reg;
    assign velocity_filtered = vel_out_reg;
    assign accel_filtered    = acc_out_reg;

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write-back hit the same joint entry");

    a_no_adjacent_same_joint: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && v_reg[1] && inr_reg[0] && inr_reg[1])
            |-> (joint_reg[0] != joint_reg[1]))
        else $error("two words for one joint in flight");

    a_flag_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> entry_valid_reg[$past(wr_addr)])
        else $error("written entry not flagged valid");

endmodule

// ----- sim/jrlp_checker.sv -----
// Watches both channels of the joint low-pass core, predicts each result and compares it.
`timescale 1ns / 1ps

module jrlp_checker #(
    parameter int JOINTS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [jrlp_pkg::JOINT_W-1:0]         joint,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_sample,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_sample,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [jrlp_pkg::JOINT_W-1:0]         joint_out,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_filtered,
    input  logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_filtered,
    output int                                   mismatches,
    output int                                   pending
);

    localparam int HIST_DEPTH = 4;
    localparam int CH_VEL     = 0;
    localparam int CH_ACC     = 1;

    typedef logic signed [79:0] wide_t;

    // 1/GAIN in Q46 and the feedback taps in Q4.30, tap on y[n-4] first
    localparam wide_t INV_GAIN_Q46 = 80'sd63225342;
    localparam wide_t FB_Y4        = -80'sd911130066;
    localparam wide_t FB_Y3        = 80'sd3794104552;
    localparam wide_t FB_Y2        = -80'sd5927934410;
    localparam wide_t FB_Y1        = 80'sd4118686313;
    localparam wide_t HALF_FF      = 80'sd2097152;
    localparam wide_t HALF_FB      = 80'sd536870912;
    localparam wide_t HALF_OUT     = 80'sd8388608;
    localparam wide_t HIST_TOP     = 80'sd36028797018963967;
    localparam wide_t HIST_BOT     = -80'sd36028797018963968;
    localparam wide_t WORD_TOP     = 80'sd2147483647;
    localparam wide_t WORD_BOT     = -80'sd2147483648;

    typedef struct packed {
        logic [jrlp_pkg::JOINT_W-1:0]  joint;
        logic [jrlp_pkg::SAMPLE_W-1:0] vel;
        logic [jrlp_pkg::SAMPLE_W-1:0] acc;
    } filtered_t;

    filtered_t filtered_q[$];

    // Per channel, per joint delay lines, entry 0 oldest
    logic signed [31:0] x_hist [2][JOINTS][HIST_DEPTH];
    logic signed [55:0] y_hist [2][JOINTS][HIST_DEPTH];

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Advance one channel of one joint by a sample and return the rounded output
    function automatic logic [31:0] lowpass_step(input int ch, input int j,
                                                 input logic signed [31:0] xin);
        wide_t s;
        wide_t acc;
        wide_t y;
        wide_t hi;
        wide_t lo;
        wide_t c;
        wide_t filt;
        int    k;
        s = wide_t'(x_hist[ch][j][0]) + wide_t'(xin)
            + wide_t'(4) * (wide_t'(x_hist[ch][j][1]) + wide_t'(x_hist[ch][j][3]))
            + wide_t'(6) * wide_t'(x_hist[ch][j][2]);
        acc = (s * INV_GAIN_Q46 + HALF_FF) >>> 22;
        for (k = 0; k < HIST_DEPTH; k++)
        begin
            case (k)
                0:       c = FB_Y4;
                1:       c = FB_Y3;
                2:       c = FB_Y2;
                default: c = FB_Y1;
            endcase
            // split y into a floor part and a non-negative 30-bit remainder
            y   = wide_t'(y_hist[ch][j][k]);
            hi  = y >>> 30;
            lo  = y - (hi <<< 30);
            acc = acc + c * hi + ((c * lo + HALF_FB) >>> 30);
        end
        if (acc > HIST_TOP)
            acc = HIST_TOP;
        if (acc < HIST_BOT)
            acc = HIST_BOT;
        for (k = 0; k < HIST_DEPTH - 1; k++)
        begin
            x_hist[ch][j][k] = x_hist[ch][j][k+1];
            y_hist[ch][j][k] = y_hist[ch][j][k+1];
        end
        x_hist[ch][j][HIST_DEPTH-1] = xin;
        y_hist[ch][j][HIST_DEPTH-1] = acc[55:0];
        filt = (acc + HALF_OUT) >>> 24;
        if (filt > WORD_TOP)
            filt = WORD_TOP;
        if (filt < WORD_BOT)
            filt = WORD_BOT;
        return filt[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            for (int ch = 0; ch < 2; ch++)
                for (int j = 0; j < JOINTS; j++)
                    for (int k = 0; k < HIST_DEPTH; k++)
                    begin
                        x_hist[ch][j][k] = '0;
                        y_hist[ch][j][k] = '0;
                    end
            filtered_q.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                    report_failure($sformatf("result with nothing expected: joint %0d",
                                             joint_out));
                else
                begin
                    want = filtered_q.pop_front();
                    if (joint_out !== want.joint)
                        report_failure($sformatf("joint_out: got %0d, expected %0d",
                                                 joint_out, want.joint));
                    if (velocity_filtered !== want.vel)
                        report_failure($sformatf("velocity_filtered: got %h, expected %h",
                                                 velocity_filtered, want.vel));
                    if (accel_filtered !== want.acc)
                        report_failure($sformatf("accel_filtered: got %h, expected %h",
                                                 accel_filtered, want.acc));
                end
            end
            if (in_valid && in_ready)
            begin
                want.joint = joint;
                if (int'(joint) < JOINTS)
                begin
                    want.vel = lowpass_step(CH_VEL, int'(joint), velocity_sample);
                    want.acc = lowpass_step(CH_ACC, int'(joint), accel_sample);
                end
                else
                begin
                    // out-of-range joint: no state touched, zero outputs
                    want.vel = '0;
                    want.acc = '0;
                end
                filtered_q.push_back(want);
            end
            pending <= filtered_q.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Stimulus, handshake pacing and verdict for the joint low-pass core.
`timescale 1ns / 1ps

module testbench;

    localparam int JOINTS = 8;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        BURST_NOISE,
        BURST_STEADY,
        BURST_PAIR,
        BURST_REPEAT
    } burst_t;

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [jrlp_pkg::JOINT_W-1:0]         joint = '0;
    logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_sample = '0;
    logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_sample = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [jrlp_pkg::JOINT_W-1:0]         joint_out;
    logic signed [jrlp_pkg::SAMPLE_W-1:0] velocity_filtered;
    logic signed [jrlp_pkg::SAMPLE_W-1:0] accel_filtered;

    int mismatches;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;

    joint_rate_iir_lowpass_core #(
        .JOINTS (JOINTS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .joint             (joint),
        .velocity_sample   (velocity_sample),
        .accel_sample      (accel_sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .joint_out         (joint_out),
        .velocity_filtered (velocity_filtered),
        .accel_filtered    (accel_filtered)
    );

    jrlp_checker #(
        .JOINTS (JOINTS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .joint             (joint),
        .velocity_sample   (velocity_sample),
        .accel_sample      (accel_sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .joint_out         (joint_out),
        .velocity_filtered (velocity_filtered),
        .accel_filtered    (accel_filtered),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random backpressure, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_reqs)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [31:0] small_noise();
        return 32'($urandom_range(0, 8192)) - 32'd4096;
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 32'd0;
            3:       return 32'($urandom_range(0, 2097152)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [2:0] j, input logic [31:0] v, input logic [31:0] a);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        joint           <= j;
        velocity_sample <= v;
        accel_sample    <= a;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold until every outstanding result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic run_bursts(input int n_words);
        int             sent;
        int             len;
        int             k;
        burst_t         mode;
        logic [2:0]     base_j;
        logic [31:0]    level_v;
        logic [31:0]    level_a;
        sent = 0;
        while (sent < n_words)
        begin
            mode    = burst_t'($urandom_range(0, 3));
            len     = $urandom_range(4, 40);
            base_j  = 3'($urandom_range(0, 7));
            level_v = pick_level();
            level_a = pick_level();
            for (k = 0; k < len; k++)
            begin
                case (mode)
                    BURST_NOISE:
                        send_word(3'($urandom_range(0, 7)), $urandom(), $urandom());
                    BURST_STEADY:
                        send_word(base_j, level_v + small_noise(), level_a + small_noise());
                    BURST_PAIR:
                        send_word(base_j ^ 3'(k & 1), level_v + small_noise(),
                                  pick_level());
                    default:
                        send_word(base_j, $urandom(), pick_level());
                endcase
            end
            sent += len;
        end
    endtask

    // Slam one joint from one rail to the other to drive both saturations
    task automatic soak_joint(input logic [2:0] j, input int n_words);
        for (int k = 0; k < n_words; k++)
            send_word(j, S_MAX, S_MIN);
        for (int k = 0; k < n_words; k++)
            send_word(j, S_MIN, S_MAX);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rails, unit values, bit patterns, back-to-back same joint
        send_word(3'd0, 32'd0, 32'd0);
        send_word(3'd1, S_MAX, S_MIN);
        send_word(3'd2, S_MIN, S_MAX);
        send_word(3'd3, 32'd1, 32'hFFFF_FFFF);
        send_word(3'd4, 32'hFFFF_FFFF, 32'd1);
        repeat (4) send_word(3'd7, S_MAX, S_MAX);
        send_word(3'd0, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(3'd1, 32'hAAAA_AAAA, 32'h5555_5555);
        for (int j = 0; j < JOINTS; j++)
            send_word(3'(j), S_MIN, S_MIN);
        for (int k = 0; k < 5; k++)
            send_word(3'd6, (k % 2 == 0) ? S_MAX : S_MIN, (k % 2 == 0) ? S_MIN : S_MAX);
        drain();

        tx_idle_pct = 33;
        rx_idle_pct <= 68;
        run_bursts(120);
        // receiver stalls while the sender keeps offering words
        hold_reqs <= hold_reqs + 1;
        run_bursts(180);
        drain();

        tx_idle_pct = 68;
        rx_idle_pct <= 33;
        run_bursts(300);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_bursts(100);
        soak_joint(3'd5, 130);
        drain();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
